// ===== src/lpst_pkg.sv =====
`default_nettype none

package lpst_pkg;

  // pixel channel and word widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned NibW   = 4;
  localparam int unsigned DigitW = 2;
  localparam int unsigned AccW   = 2 * ChanW;

  // digits per multiplier pass, words per pixel
  localparam int unsigned NumDigits = ChanW / DigitW;
  localparam int unsigned NumNibs   = 3 * ChanW / NibW;

  // configuration port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS    = 2'd0,
    REG_COLOR_CORRECT = 2'd1,
    REG_RED_FIRST     = 2'd2,
    REG_TRAILER_WORDS = 2'd3
  } reg_idx_e;

  localparam logic [7:0] BrightnessRst = 8'd255;
  localparam logic [5:0] TrailerRst    = 6'd3;
  localparam logic [5:0] TrailerMax    = 6'd32;

  // color correction factors, out of 255
  localparam logic [7:0] FactorUnity = 8'd255;
  localparam logic [7:0] FactorGreen = 8'd176;
  localparam logic [7:0] FactorBlue  = 8'd240;

  // timing digits of the spi word
  localparam logic [3:0] DigitOne  = 4'h7;
  localparam logic [3:0] DigitZero = 4'h1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_NORM  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  // bit k of the nibble drives hex digit 3-k
  function automatic logic [WordW-1:0] encode_nibble(input logic [NibW-1:0] nib);
    logic [WordW-1:0] word;
    word = '0;
    for (int k = 0; k < NibW; k++) begin
      word[NibW*(NibW-1-k) +: NibW] = nib[k] ? DigitOne : DigitZero;
    end
    return word;
  endfunction

  // exact floor(p / 255) for any product of two 8-bit values
  function automatic logic [ChanW-1:0] div255(input logic [AccW-1:0] p);
    logic [AccW:0] s;
    s = {1'b0, p} + {9'd0, p[AccW-1:ChanW]} + {{AccW{1'b0}}, 1'b1};
    return s[AccW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

// ===== src/led_pixel_spi_timing_encoder.sv =====
`default_nettype none

// channel   direction  handshake                      payload
// -------   ---------  -----------------------------  -----------------------------------
// pixel     in         in_valid_i / in_stall_o        red_i green_i blue_i last_pixel_i
// word      out        out_valid_o / out_stall_i      spi_word_o last_word_o
// config    in         psel penable pwrite pready     paddr pwdata prdata
//
// one pixel at a time: an accepted pixel passes through the radix-4 shift-add
// multiplier (a second pass with color correction), with a divide step after each
// pass, then emits one word per cycle while the output register has room: 6, plus
// a leading zero word at frame start, plus the trailer on the last pixel; the next
// pixel is taken only once the block is back in the idle state.
// reset loads the register defaults and closes any frame; out_stall_i holds the
// output register and halts word emission, and the next pixel is taken while
// the final word of the previous one still waits in the output register.

module led_pixel_spi_timing_encoder
  import lpst_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,

  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ChanW-1:0] red_i,
  input  wire logic [ChanW-1:0] green_i,
  input  wire logic [ChanW-1:0] blue_i,
  input  wire logic             last_pixel_i,

  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [WordW-1:0]      spi_word_o,
  output logic                  last_word_o,

  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  // configuration registers
  logic [7:0] brightness_q;
  logic       color_correct_q;
  logic       red_first_q;
  logic [5:0] trailer_words_q;

  reg_idx_e   reg_idx;
  logic       cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q    <= BrightnessRst;
      color_correct_q <= 1'b0;
      red_first_q     <= 1'b0;
      trailer_words_q <= TrailerRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BRIGHTNESS:    brightness_q    <= pwdata[7:0];
        REG_COLOR_CORRECT: color_correct_q <= pwdata[0];
        REG_RED_FIRST:     red_first_q     <= pwdata[0];
        REG_TRAILER_WORDS: trailer_words_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BRIGHTNESS:    prdata = {24'd0, brightness_q};
      REG_COLOR_CORRECT: prdata = {31'd0, color_correct_q};
      REG_RED_FIRST:     prdata = {31'd0, red_first_q};
      REG_TRAILER_WORDS: prdata = {26'd0, trailer_words_q};
      default:           prdata = '0;
    endcase
  end

  // datapath and sequencer state
  // lanes: 0 red, 1 green, 2 blue
  state_e            state_q, state_d;
  logic              in_frame_q, in_frame_d;
  logic              pass_q, pass_d;           // 0 brightness, 1 color correction
  logic [1:0]        digit_cnt_q, digit_cnt_d;
  logic [ChanW-1:0]  mcand_q [3];
  logic [ChanW-1:0]  mcand_d [3];
  logic [ChanW-1:0]  mplier_q [3];
  logic [ChanW-1:0]  mplier_d [3];
  logic [AccW-1:0]   acc_q [3];
  logic [AccW-1:0]   acc_d [3];
  logic [3*ChanW-1:0] data_q, data_d;          // nibble shift register, msb out first
  logic              lead_q, lead_d;           // leading frame word pending
  logic [2:0]        nib_cnt_q, nib_cnt_d;
  logic [5:0]        trail_q, trail_d;

  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  spi_word_q, spi_word_d;
  logic              last_word_q, last_word_d;

  logic              in_accept;
  logic              slot_free;
  logic [ChanW-1:0]  scaled [3];
  logic [5:0]        trail_sat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign trail_sat   = (trailer_words_q > TrailerMax) ? TrailerMax : trailer_words_q;

  assign out_valid_o = out_valid_q;
  assign spi_word_o  = spi_word_q;
  assign last_word_o = last_word_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      scaled[l] = div255(acc_q[l]);
    end
  end

  always_comb begin
    state_d     = state_q;
    in_frame_d  = in_frame_q;
    pass_d      = pass_q;
    digit_cnt_d = digit_cnt_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    data_d      = data_q;
    lead_d      = lead_q;
    nib_cnt_d   = nib_cnt_q;
    trail_d     = trail_q;
    out_valid_d = out_valid_q;
    spi_word_d  = spi_word_q;
    last_word_d = last_word_q;

    // output register drains when taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mcand_d[0]  = red_i;
          mcand_d[1]  = green_i;
          mcand_d[2]  = blue_i;
          for (int l = 0; l < 3; l++) begin
            mplier_d[l] = brightness_q;
            acc_d[l]    = '0;
          end
          pass_d      = 1'b0;
          digit_cnt_d = '0;
          lead_d      = !in_frame_q;
          in_frame_d  = !last_pixel_i;
          trail_d     = last_pixel_i ? trail_sat : 6'd0;
          state_d     = ST_SCALE;
        end
      end

      // msb-first shift-add, one 2-bit digit of the multiplier per cycle
      ST_SCALE: begin
        for (int l = 0; l < 3; l++) begin
          acc_d[l] = {acc_q[l][AccW-DigitW-1:0], {DigitW{1'b0}}}
                   + AccW'(mcand_q[l]) * AccW'(mplier_q[l][ChanW-1 -: DigitW]);
          mplier_d[l] = {mplier_q[l][ChanW-DigitW-1:0], {DigitW{1'b0}}};
        end
        digit_cnt_d = digit_cnt_q + 2'd1;
        if (digit_cnt_q == 2'(NumDigits - 1)) begin
          state_d = ST_NORM;
        end
      end

      ST_NORM: begin
        if (!pass_q && color_correct_q) begin
          for (int l = 0; l < 3; l++) begin
            mcand_d[l] = scaled[l];
            acc_d[l]   = '0;
          end
          mplier_d[0] = FactorUnity;
          mplier_d[1] = FactorGreen;
          mplier_d[2] = FactorBlue;
          pass_d      = 1'b1;
          digit_cnt_d = '0;
          state_d     = ST_SCALE;
        end else begin
          data_d    = red_first_q ? {scaled[0], scaled[1], scaled[2]}
                                  : {scaled[1], scaled[0], scaled[2]};
          nib_cnt_d = 3'(NumNibs);
          state_d   = ST_EMIT;
        end
      end

      // one word per cycle while the output register has room
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (lead_q) begin
            spi_word_d  = '0;
            last_word_d = 1'b0;
            lead_d      = 1'b0;
          end else if (nib_cnt_q != 3'd0) begin
            spi_word_d  = encode_nibble(data_q[3*ChanW-1 -: NibW]);
            data_d      = {data_q[3*ChanW-NibW-1:0], {NibW{1'b0}}};
            nib_cnt_d   = nib_cnt_q - 3'd1;
            last_word_d = (nib_cnt_q == 3'd1) && (trail_q == 6'd0);
            if ((nib_cnt_q == 3'd1) && (trail_q == 6'd0)) begin
              state_d = ST_IDLE;
            end
          end else begin
            spi_word_d  = '0;
            trail_d     = trail_q - 6'd1;
            last_word_d = (trail_q == 6'd1);
            if (trail_q == 6'd1) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_frame_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pass_q      <= 1'b0;
      digit_cnt_q <= '0;
      lead_q      <= 1'b0;
      nib_cnt_q   <= '0;
      trail_q     <= '0;
    end else begin
      state_q     <= state_d;
      in_frame_q  <= in_frame_d;
      out_valid_q <= out_valid_d;
      pass_q      <= pass_d;
      digit_cnt_q <= digit_cnt_d;
      lead_q      <= lead_d;
      nib_cnt_q   <= nib_cnt_d;
      trail_q     <= trail_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    acc_q       <= acc_d;
    data_q      <= data_d;
    spi_word_q  <= spi_word_d;
    last_word_q <= last_word_d;
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  import lpst_pkg::*;

  // scaling constants and limits of the encoder
  localparam logic [7:0]  FullScale   = 8'd255;
  localparam logic [7:0]  GreenNum    = 8'd176;
  localparam logic [7:0]  BlueNum     = 8'd240;
  localparam logic [5:0]  TrailerCap  = 6'd32;
  localparam logic [3:0]  MarkDigit   = 4'h7;
  localparam logic [3:0]  SpaceDigit  = 4'h1;
  localparam int unsigned SettleCyc   = 60;
  localparam int unsigned HoldOffCyc  = 400;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseItems  = 62;
  localparam int unsigned NumPhases   = 8;

  typedef struct {
    logic [15:0] word;
    logic        last;
  } word_due_t;

  // expected spi words and the encoder's register and frame state
  class pixel_word_board;
    logic [7:0]  brightness;
    logic        color_correct;
    logic        red_first;
    logic [5:0]  trailer_words;
    logic        in_frame;
    word_due_t   words_due[$];
    int unsigned failures;

    function new();
      brightness    = 8'd255;
      color_correct = 1'b0;
      red_first     = 1'b0;
      trailer_words = 6'd3;
      in_frame      = 1'b0;
      failures      = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_BRIGHTNESS:    brightness    = v[7:0];
        REG_COLOR_CORRECT: color_correct = v[0];
        REG_RED_FIRST:     red_first     = v[0];
        REG_TRAILER_WORDS: trailer_words = v[5:0];
        default: ;
      endcase
    endfunction

    // bit k of the nibble picks hex digit 3-k
    function logic [15:0] timing_word(logic [3:0] nib);
      logic [15:0] w;
      w = '0;
      for (int k = 0; k < 4; k++) begin
        w[4*(3-k) +: 4] = nib[k] ? MarkDigit : SpaceDigit;
      end
      return w;
    endfunction

    function logic [7:0] scale(logic [7:0] c, logic [7:0] f);
      logic [15:0] p;
      p = 16'(c) * 16'(f);
      return 8'(p / 16'd255);
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
      logic [15:0] seq[$];
      logic [7:0]  chans[3];
      logic [5:0]  trail;
      word_due_t   e;
      if (!in_frame) begin
        seq.push_back(16'h0000);
        in_frame = 1'b1;
      end
      if (brightness != FullScale) begin
        r = scale(r, brightness);
        g = scale(g, brightness);
        b = scale(b, brightness);
      end
      if (color_correct) begin
        g = scale(g, GreenNum);
        b = scale(b, BlueNum);
      end
      chans[0] = red_first ? r : g;
      chans[1] = red_first ? g : r;
      chans[2] = b;
      foreach (chans[c]) begin
        seq.push_back(timing_word(chans[c][7:4]));
        seq.push_back(timing_word(chans[c][3:0]));
      end
      if (last) begin
        trail = (trailer_words > TrailerCap) ? TrailerCap : trailer_words;
        repeat (trail) seq.push_back(16'h0000);
        in_frame = 1'b0;
      end
      foreach (seq[i]) begin
        e.word = seq[i];
        e.last = (i == seq.size() - 1);
        words_due.push_back(e);
      end
    endfunction

    function void check_word(logic [15:0] word, logic last);
      word_due_t e;
      if (words_due.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("unexpected word %h last %b", word, last);
        return;
      end
      e = words_due.pop_front();
      if (word !== e.word || last !== e.last) begin
        failures++;
        if (failures <= MaxReports)
          $display("word mismatch: expected %h last %b, got %h last %b",
                   e.word, e.last, word, last);
      end
    endfunction

    function int pending();
      return words_due.size();
    endfunction
  endclass

  // dut ports
  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [ChanW-1:0] red_i, green_i, blue_i;
  logic             last_pixel_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [WordW-1:0] spi_word_o;
  logic             last_word_o;
  logic             psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  pixel_word_board board;

  // idle and stall rates of the current phase, percent
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  // long receiver hold-off requested by the sequence, taken by the stall process
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  led_pixel_spi_timing_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .last_pixel_i (last_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .spi_word_o   (spi_word_o),
    .last_word_o  (last_word_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  wire pixel_taken = rst_ni && in_valid_i && (in_stall_o === 1'b0);
  wire word_taken  = rst_ni && (out_valid_o === 1'b1) && !out_stall_i;
  wire reg_written = psel && penable && pwrite && (pready === 1'b1);

  // predict on every accepted pixel transaction
  always @(posedge clk_i) begin
    if (pixel_taken) board.note_pixel(red_i, green_i, blue_i, last_pixel_i);
  end

  // compare every accepted word transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (word_taken) board.check_word(spi_word_o, last_word_o);
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: too long with no transaction on any port
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pixel_taken || word_taken || reg_written) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("** led_pixel_spi_timing_encoder: FAILED **");
        $finish;
      end
    end
  end

  // offer one pixel, with random idle cycles ahead of it, and wait until taken
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    red_i        <= r;
    green_i      <= g;
    blue_i       <= b;
    last_pixel_i <= last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // drop valid, wait for every expected word, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // apb setup and access cycles; upper bits carry junk the block must mask off
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value,
                           input logic [31:0] mask);
    logic [31:0] data;
    data = ($urandom() & ~mask) | (value & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  task automatic write_cfg(input logic [7:0] br, input logic cc, input logic rf,
                           input logic [5:0] tr);
    settle();
    apb_write(REG_BRIGHTNESS, 32'(br), 32'h0000_00ff);
    apb_write(REG_COLOR_CORRECT, 32'(cc), 32'h0000_0001);
    apb_write(REG_RED_FIRST, 32'(rf), 32'h0000_0001);
    apb_write(REG_TRAILER_WORDS, 32'(tr), 32'h0000_003f);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int unsigned left;
    int unsigned flen;
    logic [7:0]  br;
    logic [5:0]  tr;
    logic        last;

    board = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    in_valid_i   <= 1'b0;
    red_i        <= '0;
    green_i      <= '0;
    blue_i       <= '0;
    last_pixel_i <= 1'b0;
    out_stall_i  <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset defaults, frame start and end, channel extremes
    send_idle_pct = 22;
    stall_pct     = 22;
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'ha5, 8'h5a, 8'h0f, 1'b0);
    send_pixel(8'h80, 8'h01, 8'hfe, 1'b1);
    send_pixel(8'h12, 8'h34, 8'h56, 1'b1);

    // zero brightness, correction on, red first, no trailer
    write_cfg(8'd0, 1'b1, 1'b1, 6'd0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'hff, 8'h00, 8'h80, 1'b1);

    // oversized trailer saturates
    write_cfg(8'd254, 1'b1, 1'b0, 6'd63);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'h01, 8'h01, 8'h01, 1'b1);

    // minimum nonzero brightness with the longest legal trailer
    write_cfg(8'd1, 1'b0, 1'b1, 6'd32);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'hfe, 8'hfd, 8'hfc, 1'b1);

    write_cfg(8'd128, 1'b1, 1'b1, 6'd33);
    send_pixel(8'hff, 8'hc8, 8'h64, 1'b1);

    // full brightness with color correction only
    write_cfg(8'd255, 1'b1, 1'b0, 6'd1);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    send_pixel(8'hff, 8'h00, 8'hff, 1'b1);

    // random phases: mostly well-formed frames, some stray frame ends
    for (int ph = 0; ph < NumPhases; ph++) begin
      case ($urandom_range(4))
        0:       br = 8'd0;
        1:       br = 8'd255;
        2:       br = 8'd254;
        default: br = 8'($urandom_range(255));
      endcase
      tr = ($urandom_range(7) == 0) ? 6'($urandom_range(7, 63)) : 6'($urandom_range(6));
      write_cfg(br, 1'($urandom_range(1)), 1'($urandom_range(1)), tr);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 78; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      // receiver holds off while the sender keeps offering, filling the block
      if (ph == 0) hold_req = HoldOffCyc;
      left = PhaseItems;
      while (left > 0) begin
        flen = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
        for (int i = 0; i < flen && left > 0; i++) begin
          last = (i == flen - 1);
          if ($urandom_range(7) == 0) last = 1'($urandom_range(1));
          send_pixel(rand_chan(), rand_chan(), rand_chan(), last);
          left--;
        end
      end
    end

    settle();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("** led_pixel_spi_timing_encoder: PASSED **");
    end else begin
      $display("** led_pixel_spi_timing_encoder: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
